// ===== hdl/mlpbp_pkg.sv =====
// Shared types, codes and arithmetic helpers for the backprop train-step unit.
// Used by mlpbp_ctrl, mlpbp_dp and the top level; no dependencies.
package mlpbp_pkg;

	localparam int INPUT_COUNT = 3;
	localparam int WEIGHT_LIMIT = 20480;
	localparam int ONE_Q = 4096;
	localparam int TANH_MAX = 4093;

	localparam logic [1:0] REQ_INFER = 2'd0;
	localparam logic [1:0] REQ_TRAIN = 2'd1;
	localparam logic [1:0] REQ_LOAD = 2'd2;

	localparam logic [7:0] REG_RATE_HO = 8'd0;
	localparam logic [7:0] REG_RATE_IH = 8'd1;

	localparam logic [2:0] MA_X = 3'd0;
	localparam logic [2:0] MA_H = 3'd1;
	localparam logic [2:0] MA_RHO = 3'd2;
	localparam logic [2:0] MA_RIH = 3'd3;
	localparam logic [2:0] MA_T = 3'd4;
	localparam logic [2:0] MA_D = 3'd5;

	localparam logic [2:0] MB_RD = 3'd0;
	localparam logic [2:0] MB_ERR = 3'd1;
	localparam logic [2:0] MB_H = 3'd2;
	localparam logic [2:0] MB_G = 3'd3;
	localparam logic [2:0] MB_X = 3'd4;

	localparam logic [1:0] WR_LOAD = 2'd0;
	localparam logic [1:0] WR_OUT = 2'd1;
	localparam logic [1:0] WR_HID = 2'd2;

	typedef struct packed {
		logic cap;
		logic rd_en;
		logic wr_en;
		logic [1:0] wr_sel;
		logic mul_en;
		logic [2:0] a_sel;
		logic [2:0] b_sel;
		logic acc_clr;
		logic acc_add;
		logic hpot_ld;
		logic h_ld;
		logic pred_ld;
		logic err_ld;
		logic clr_res;
		logic t_ld;
		logic d_ld;
		logic g_ld;
		logic res_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_train;
	} dp_stat_t;

	function automatic logic signed [52:0] round_sh(input logic signed [51:0] v,
			input int unsigned s);
		logic signed [52:0] t;
		t = {v[51], v} + (53'sd1 <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [52:0] v);
		if (v > 53'sd32767) return 16'sh7fff;
		if (v < -53'sd32768) return -16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic [12:0] tanh_tab(input logic [4:0] i);
		case (i)
			5'd0: return 13'd0;
			5'd1: return 13'd1003;
			5'd2: return 13'd1893;
			5'd3: return 13'd2602;
			5'd4: return 13'd3119;
			5'd5: return 13'd3475;
			5'd6: return 13'd3707;
			5'd7: return 13'd3856;
			5'd8: return 13'd3949;
			5'd9: return 13'd4006;
			5'd10: return 13'd4041;
			5'd11: return 13'd4062;
			5'd12: return 13'd4076;
			5'd13: return 13'd4084;
			5'd14: return 13'd4089;
			5'd15: return 13'd4091;
			default: return 13'd4093;
		endcase
	endfunction

	function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
		logic [16:0] a;
		logic [4:0] i;
		logic [12:0] lo;
		logic [12:0] hi;
		logic [20:0] step;
		logic [12:0] y;
		a = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
		i = {1'b0, a[13:10]};
		lo = tanh_tab(i);
		hi = tanh_tab(i + 5'd1);
		step = 21'(hi - lo) * 21'(a[9:0]);
		if (a[16:14] != 3'd0) y = 13'(TANH_MAX);
		else y = lo + 13'((step + 21'd512) >> 10);
		return x[15] ? (16'sd0 - $signed({3'b0, y})) : $signed({3'b0, y});
	endfunction

endpackage

// ===== hdl/mlpbp_dp.sv =====
// Datapath: weight memory, shared multiplier, accumulator and scratch registers.
// Depends on mlpbp_pkg; driven by mlpbp_ctrl.
module mlpbp_dp #(
	parameter int HIDDEN_UNITS = 4,
	parameter int AW = 4,
	parameter int IW = 2
) (
	input logic clk,
	input logic arst_n,
	input mlpbp_pkg::dp_cmd_t cmd,
	output mlpbp_pkg::dp_stat_t stat,
	input logic [AW-1:0] addr,
	input logic [IW-1:0] hid_idx,
	input logic [1:0] in_k,
	input logic cfg_we,
	input logic [7:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic [1:0] req_type,
	input logic signed [15:0] feature_a,
	input logic signed [15:0] feature_b,
	input logic signed [15:0] feature_bias,
	input logic signed [15:0] target,
	input logic [5:0] weight_index,
	input logic signed [15:0] weight_value,
	output logic signed [15:0] prediction,
	output logic signed [15:0] error
);
	import mlpbp_pkg::*;

	localparam int DEPTH = 4 * HIDDEN_UNITS;

	logic [15:0] rate_ho_q, rate_ih_q;
	logic [1:0] req_q;
	logic signed [15:0] x_q [INPUT_COUNT];
	logic signed [15:0] target_q, wval_q;
	logic [5:0] widx_q;
	logic signed [15:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic signed [15:0] rd_q;
	logic signed [15:0] h_q [HIDDEN_UNITS];
	logic signed [33:0] a_val;
	logic signed [16:0] b_val;
	logic signed [50:0] prod_q;
	logic signed [39:0] acc_q;
	logic signed [15:0] hpot_q, pred_q, err_q, d_q, g_q;
	logic signed [33:0] t_q;
	logic signed [15:0] x_sel, h_sel;
	logic signed [52:0] delta, diff, hsq;
	logic signed [15:0] wr_data;
	logic [AW-1:0] wr_addr;
	logic wr_ok;

	assign stat.is_load = (req_q == REQ_LOAD);
	assign stat.is_train = (req_q == REQ_TRAIN);
	assign x_sel = x_q[in_k];
	assign h_sel = h_q[hid_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_ho_q <= 16'd655;
			rate_ih_q <= 16'd6554;
		end else if (cfg_we) begin
			if (cfg_index == REG_RATE_HO) rate_ho_q <= cfg_data;
			else if (cfg_index == REG_RATE_IH) rate_ih_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req_type;
			x_q[0] <= feature_a;
			x_q[1] <= feature_b;
			x_q[2] <= feature_bias;
			target_q <= target;
			widx_q <= weight_index;
			wval_q <= weight_value;
		end
	end

	always_comb begin
		case (cmd.a_sel)
			MA_X: a_val = 34'(x_sel);
			MA_H: a_val = 34'(h_sel);
			MA_RHO: a_val = $signed({18'd0, rate_ho_q});
			MA_RIH: a_val = $signed({18'd0, rate_ih_q});
			MA_T: a_val = t_q;
			MA_D: a_val = 34'(d_q);
			default: a_val = '0;
		endcase
		case (cmd.b_sel)
			MB_RD: b_val = 17'(rd_q);
			MB_ERR: b_val = 17'(err_q);
			MB_H: b_val = 17'(h_sel);
			MB_G: b_val = 17'(g_q);
			MB_X: b_val = 17'(x_sel);
			default: b_val = '0;
		endcase
	end

	always_comb begin
		delta = round_sh(52'(prod_q), 28);
		hsq = round_sh(52'(prod_q), 12);
		diff = 53'(rd_q) - delta;
		wr_addr = addr;
		wr_ok = cmd.wr_en;
		case (cmd.wr_sel)
			WR_LOAD: begin
				wr_data = wval_q;
				wr_addr = widx_q[AW-1:0];
				wr_ok = cmd.wr_en && ({1'b0, widx_q} < 7'(DEPTH));
			end
			WR_OUT: begin
				if (diff > 53'(WEIGHT_LIMIT)) wr_data = 16'(WEIGHT_LIMIT);
				else if (diff < -53'(WEIGHT_LIMIT)) wr_data = -16'(WEIGHT_LIMIT);
				else wr_data = diff[15:0];
			end
			WR_HID: wr_data = sat16(diff);
			default: wr_data = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_ok) mem_q[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_q <= vld_q[addr] ? mem_q[addr] : 16'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (wr_ok) vld_q[wr_addr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q <= a_val * b_val;
		if (cmd.acc_clr) acc_q <= '0;
		else if (cmd.acc_add) acc_q <= acc_q + 40'(prod_q);
		if (cmd.hpot_ld) hpot_q <= sat16(round_sh(52'(acc_q), 12));
		if (cmd.h_ld) h_q[hid_idx] <= tanh_q(hpot_q);
		if (cmd.clr_res) begin
			pred_q <= '0;
			err_q <= '0;
		end else begin
			if (cmd.pred_ld) pred_q <= sat16(round_sh(52'(acc_q), 12));
			if (cmd.err_ld) err_q <= sat16(53'(pred_q) - 53'(target_q));
		end
		if (cmd.t_ld) t_q <= prod_q[33:0];
		if (cmd.d_ld) d_q <= 16'(ONE_Q) - hsq[15:0];
		if (cmd.g_ld) g_q <= sat16(round_sh(52'(prod_q), 24));
		if (cmd.res_ld) begin
			prediction <= pred_q;
			error <= err_q;
		end
	end

endmodule

// ===== hdl/mlpbp_ctrl.sv =====
// Sequencer for the backprop unit: walks weight load, forward pass, output and hidden updates.
// Depends on mlpbp_pkg; commands mlpbp_dp.
module mlpbp_ctrl #(
	parameter int HIDDEN_UNITS = 4,
	parameter int AW = 4,
	parameter int IW = 2
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input mlpbp_pkg::dp_stat_t stat,
	output mlpbp_pkg::dp_cmd_t cmd,
	output logic [AW-1:0] addr,
	output logic [IW-1:0] hid_idx,
	output logic [1:0] in_k
);
	import mlpbp_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_LOAD = 5'd2;
	localparam logic [4:0] S_F_RD = 5'd3;
	localparam logic [4:0] S_F_MUL = 5'd4;
	localparam logic [4:0] S_F_ACC = 5'd5;
	localparam logic [4:0] S_F_HS = 5'd6;
	localparam logic [4:0] S_F_TH = 5'd7;
	localparam logic [4:0] S_P_RD = 5'd8;
	localparam logic [4:0] S_P_MUL = 5'd9;
	localparam logic [4:0] S_P_ACC = 5'd10;
	localparam logic [4:0] S_P_FIN = 5'd11;
	localparam logic [4:0] S_ERR = 5'd12;
	localparam logic [4:0] S_O_RD = 5'd13;
	localparam logic [4:0] S_O_T = 5'd14;
	localparam logic [4:0] S_O_MUL = 5'd15;
	localparam logic [4:0] S_O_WR = 5'd16;
	localparam logic [4:0] S_H_RD = 5'd17;
	localparam logic [4:0] S_H_D = 5'd18;
	localparam logic [4:0] S_H_M1 = 5'd19;
	localparam logic [4:0] S_H_T1 = 5'd20;
	localparam logic [4:0] S_H_M2 = 5'd21;
	localparam logic [4:0] S_H_G = 5'd22;
	localparam logic [4:0] S_H_M3 = 5'd23;
	localparam logic [4:0] S_H_T2 = 5'd24;
	localparam logic [4:0] S_W_RD = 5'd25;
	localparam logic [4:0] S_W_MUL = 5'd26;
	localparam logic [4:0] S_W_WR = 5'd27;
	localparam logic [4:0] S_DONE = 5'd28;

	localparam logic [AW-1:0] HC = AW'(HIDDEN_UNITS);
	localparam logic [AW-1:0] OUT_BASE = AW'(3 * HIDDEN_UNITS);
	localparam logic [IW-1:0] I_LAST = IW'(HIDDEN_UNITS - 1);
	localparam logic [1:0] K_LAST = 2'(INPUT_COUNT - 1);

	logic [4:0] state_q, state_d;
	logic [IW-1:0] i_q, i_d;
	logic [1:0] k_q, k_d;
	logic ov_q;
	logic [AW-1:0] hid_addr, out_addr;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign hid_idx = i_q;
	assign in_k = k_q;
	assign hid_addr = AW'(k_q) * HC + AW'(i_q);
	assign out_addr = OUT_BASE + AW'(i_q);

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		k_d = k_q;
		cmd = '0;
		addr = hid_addr;
		case (state_q)
			S_IDLE: begin
				cmd.cap = in_valid;
				i_d = '0;
				k_d = '0;
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				cmd.acc_clr = 1'b1;
				state_d = stat.is_load ? S_LOAD : S_F_RD;
			end
			S_LOAD: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_LOAD;
				cmd.clr_res = 1'b1;
				state_d = S_DONE;
			end
			S_F_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_F_MUL;
			end
			S_F_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_X;
				cmd.b_sel = MB_RD;
				state_d = S_F_ACC;
			end
			S_F_ACC: begin
				cmd.acc_add = 1'b1;
				if (k_q == K_LAST) begin
					k_d = '0;
					state_d = S_F_HS;
				end else begin
					k_d = k_q + 2'd1;
					state_d = S_F_RD;
				end
			end
			S_F_HS: begin
				cmd.hpot_ld = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d = S_F_TH;
			end
			S_F_TH: begin
				cmd.h_ld = 1'b1;
				if (i_q == I_LAST) begin
					i_d = '0;
					state_d = S_P_RD;
				end else begin
					i_d = i_q + 1'b1;
					state_d = S_F_RD;
				end
			end
			S_P_RD: begin
				addr = out_addr;
				cmd.rd_en = 1'b1;
				state_d = S_P_MUL;
			end
			S_P_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_H;
				cmd.b_sel = MB_RD;
				state_d = S_P_ACC;
			end
			S_P_ACC: begin
				cmd.acc_add = 1'b1;
				if (i_q == I_LAST) begin
					i_d = '0;
					state_d = S_P_FIN;
				end else begin
					i_d = i_q + 1'b1;
					state_d = S_P_RD;
				end
			end
			S_P_FIN: begin
				cmd.pred_ld = 1'b1;
				state_d = S_ERR;
			end
			S_ERR: begin
				cmd.err_ld = 1'b1;
				state_d = stat.is_train ? S_O_RD : S_DONE;
			end
			S_O_RD: begin
				addr = out_addr;
				cmd.rd_en = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_RHO;
				cmd.b_sel = MB_ERR;
				state_d = S_O_T;
			end
			S_O_T: begin
				cmd.t_ld = 1'b1;
				state_d = S_O_MUL;
			end
			S_O_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_T;
				cmd.b_sel = MB_H;
				state_d = S_O_WR;
			end
			S_O_WR: begin
				addr = out_addr;
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_OUT;
				if (i_q == I_LAST) begin
					i_d = '0;
					state_d = S_H_RD;
				end else begin
					i_d = i_q + 1'b1;
					state_d = S_O_RD;
				end
			end
			S_H_RD: begin
				addr = out_addr;
				cmd.rd_en = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_H;
				cmd.b_sel = MB_H;
				state_d = S_H_D;
			end
			S_H_D: begin
				cmd.d_ld = 1'b1;
				state_d = S_H_M1;
			end
			S_H_M1: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_D;
				cmd.b_sel = MB_RD;
				state_d = S_H_T1;
			end
			S_H_T1: begin
				cmd.t_ld = 1'b1;
				state_d = S_H_M2;
			end
			S_H_M2: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_T;
				cmd.b_sel = MB_ERR;
				state_d = S_H_G;
			end
			S_H_G: begin
				cmd.g_ld = 1'b1;
				state_d = S_H_M3;
			end
			S_H_M3: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_RIH;
				cmd.b_sel = MB_G;
				state_d = S_H_T2;
			end
			S_H_T2: begin
				cmd.t_ld = 1'b1;
				k_d = '0;
				state_d = S_W_RD;
			end
			S_W_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_W_MUL;
			end
			S_W_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel = MA_T;
				cmd.b_sel = MB_X;
				state_d = S_W_WR;
			end
			S_W_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_HID;
				if (k_q == K_LAST) begin
					k_d = '0;
					if (i_q == I_LAST) begin
						i_d = '0;
						state_d = S_DONE;
					end else begin
						i_d = i_q + 1'b1;
						state_d = S_H_RD;
					end
				end else begin
					k_d = k_q + 2'd1;
					state_d = S_W_RD;
				end
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.res_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			k_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			k_q <= k_d;
			if (cmd.res_ld) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/mlp_backprop_train_step_unit.sv =====
// Top level of the online-trained one-hidden-layer tanh perceptron.
// Depends on mlpbp_pkg, mlpbp_ctrl and mlpbp_dp.
//
// Usage: one item enters on the s_axis channel (tuser = request: infer, train,
// load weight); one result leaves on m_axis (prediction, error) per item.
// Items are processed one at a time through one shared multiplier and a
// single-port weight memory; s_axis_tready is high only while idle.
// The time from accept to result depends on the request (load, infer or train)
// and is set by the multiplier issue sequence.
// The result sits in an output register: the next item is accepted while it
// waits; a stalled m_axis holds the following result in the datapath until
// the register frees.
// Learning rates are written on the cfg channel (always ready); write them only while idle (not enforced).
// Reset: rates return to defaults, all weights read as zero, no result pending.
module mlp_backprop_train_step_unit #(
	parameter int HIDDEN_UNITS = 4
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// feature_a[15:0] feature_b[31:16] feature_bias[47:32] target[63:48]
	// weight_index[69:64] weight_value[85:70], zero pad [87:86]
	input logic [87:0] s_axis_tdata,
	// req_type[1:0]
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// prediction[15:0] error[31:16]
	output logic [31:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [15:0] cfg_data
);
	import mlpbp_pkg::*;

	localparam int AW = $clog2(4 * HIDDEN_UNITS);
	localparam int IW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [AW-1:0] addr;
	logic [IW-1:0] hid_idx;
	logic [1:0] in_k;
	logic signed [15:0] prediction, error;

	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {error, prediction};

	mlpbp_ctrl #(.HIDDEN_UNITS(HIDDEN_UNITS), .AW(AW), .IW(IW)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.stat(stat),
		.cmd(cmd),
		.addr(addr),
		.hid_idx(hid_idx),
		.in_k(in_k)
	);

	mlpbp_dp #(.HIDDEN_UNITS(HIDDEN_UNITS), .AW(AW), .IW(IW)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.addr(addr),
		.hid_idx(hid_idx),
		.in_k(in_k),
		.cfg_we(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_type(s_axis_tuser),
		.feature_a(s_axis_tdata[15:0]),
		.feature_b(s_axis_tdata[31:16]),
		.feature_bias(s_axis_tdata[47:32]),
		.target(s_axis_tdata[63:48]),
		.weight_index(s_axis_tdata[69:64]),
		.weight_value(s_axis_tdata[85:70]),
		.prediction(prediction),
		.error(error)
	);

endmodule

// ===== tb/tb_mlp_backprop_train_step_unit.sv =====
// Testbench for mlp_backprop_train_step_unit: drives infer, train and load transfers,
// predicts prediction/error with an internal fixed-point network model and checks results.
// Depends on mlpbp_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_mlp_backprop_train_step_unit;
	import mlpbp_pkg::*;

	localparam int HU = 4;
	localparam int HWN = INPUT_COUNT * HU;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	mlp_backprop_train_step_unit #(.HIDDEN_UNITS(HU)) dut (.*);

	always #5 clk = ~clk;

	typedef struct packed {
		logic signed [15:0] err;
		logic signed [15:0] pred;
	} net_out_t;

	net_out_t pending_q[$];
	int fail_cnt = 0;
	bit quiet = 0;
	int hold_cycles = 0;

	// network state mirror
	longint unsigned lr_out, lr_hid;
	int w_hid[HWN];
	int w_out[HU];
	int lut[17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
		4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};

	function automatic longint rnd(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic int clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	function automatic int act(int x);
		int a, y, i, f;
		a = x < 0 ? -x : x;
		if (a >= 16384) y = lut[16];
		else begin
			i = a >> 10;
			f = a & 1023;
			y = lut[i] + int'(rnd(longint'(lut[i + 1] - lut[i]) * f, 10));
		end
		return x < 0 ? -y : y;
	endfunction

	function automatic net_out_t net_step(logic [1:0] req, logic [87:0] d);
		int x[INPUT_COUNT];
		int h[HU];
		int tgt, pred, err, dd, g, idx;
		longint acc, w;
		net_out_t r;
		if (req == REQ_LOAD) begin
			idx = d[69:64];
			if (idx < HWN) w_hid[idx] = int'($signed(d[85:70]));
			else if (idx < HWN + HU) w_out[idx - HWN] = int'($signed(d[85:70]));
			return '0;
		end
		for (int k = 0; k < INPUT_COUNT; k++) x[k] = int'($signed(d[16*k +: 16]));
		tgt = int'($signed(d[63:48]));
		for (int i = 0; i < HU; i++) begin
			acc = 0;
			for (int k = 0; k < INPUT_COUNT; k++) acc += longint'(x[k]) * w_hid[k*HU + i];
			h[i] = act(clip16(rnd(acc, 12)));
		end
		acc = 0;
		for (int i = 0; i < HU; i++) acc += longint'(h[i]) * w_out[i];
		pred = clip16(rnd(acc, 12));
		err = clip16(longint'(pred) - tgt);
		if (req == REQ_TRAIN) begin
			for (int i = 0; i < HU; i++) begin
				w = w_out[i] - rnd(longint'(lr_out) * err * h[i], 28);
				if (w < -WEIGHT_LIMIT) w = -WEIGHT_LIMIT;
				if (w > WEIGHT_LIMIT) w = WEIGHT_LIMIT;
				w_out[i] = int'(w);
			end
			for (int i = 0; i < HU; i++) begin
				dd = ONE_Q - int'(rnd(longint'(h[i]) * h[i], 12));
				g = clip16(rnd(longint'(dd) * w_out[i] * err, 24));
				for (int k = 0; k < INPUT_COUNT; k++) begin
					idx = k*HU + i;
					w_hid[idx] = clip16(w_hid[idx] - rnd(longint'(g) * longint'(lr_hid) * x[k], 28));
				end
			end
		end
		r.pred = pred[15:0];
		r.err = err[15:0];
		return r;
	endfunction

	task automatic send_item(logic [1:0] req, logic [15:0] fa, logic [15:0] fb,
			logic [15:0] fc, logic [15:0] tg, logic [5:0] wi, logic [15:0] wv);
		logic [87:0] d;
		d = {2'b00, wv, wi, tg, fc, fb, fa};
		if (!quiet && $urandom_range(3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tdata <= d;
		s_axis_tuser <= req;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_q.push_back(net_step(req, d));
		@(negedge clk);
	endtask

	task automatic wait_drain();
		int n;
		n = 0;
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		while (n < 200) begin
			@(negedge clk);
			n++;
		end
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_RATE_HO) lr_out = v;
		else if (idx == REG_RATE_IH) lr_hid = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				fail_cnt++;
			end else begin
				net_out_t e;
				e = pending_q.pop_front();
				if (m_axis_tdata[15:0] !== e.pred) begin
					$error("prediction exp %0d got %0d", e.pred, $signed(m_axis_tdata[15:0]));
					fail_cnt++;
				end
				if (m_axis_tdata[31:16] !== e.err) begin
					$error("error exp %0d got %0d", e.err, $signed(m_axis_tdata[31:16]));
					fail_cnt++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(3) == 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= $urandom_range(0, 4);
		end else m_axis_tready <= 1'b1;
	end

	function automatic logic [15:0] rfeat();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 12288)) - 6144);
			2: return 16'h1000;
			default: return 16'($signed($urandom_range(0, 4096)) - 2048);
		endcase
	endfunction

	task automatic load_random_weights();
		for (int i = 0; i < HWN + HU; i++)
			send_item(REQ_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 6'(i),
				16'($signed($urandom_range(0, 16384)) - 8192));
	endtask

	task automatic test_directed();
		send_item(REQ_INFER, 16'h7fff, 16'h8000, 16'h1000, 16'h7fff, 6'd0, 16'd0);
		send_item(REQ_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0, 16'h7fff);
		send_item(REQ_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 6'd5, 16'h8000);
		send_item(REQ_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 6'd12, 16'h7fff);
		send_item(REQ_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 6'd15, 16'h8000);
		send_item(REQ_LOAD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 6'd63, 16'hffff);
		send_item(REQ_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 6'd16, 16'h1234);
		send_item(REQ_INFER, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 6'd0, 16'd0);
		send_item(REQ_SPARE, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 6'd63, 16'hffff);
		send_item(REQ_TRAIN, 16'h7fff, 16'h8000, 16'h1000, 16'h8000, 6'd0, 16'd0);
		send_item(REQ_TRAIN, 16'h1000, 16'h0, 16'h1000, 16'h0, 6'd0, 16'd0);
		send_item(REQ_INFER, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 6'd0, 16'd0);
		send_item(REQ_TRAIN, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 6'd0, 16'd0);
		send_item(REQ_INFER, 16'h0400, 16'hfc00, 16'h1000, 16'h0, 6'd0, 16'd0);
	endtask

	task automatic test_random(int n);
		int r;
		for (int j = 0; j < n; j++) begin
			r = $urandom_range(99);
			if (r < 4) load_random_weights();
			else if (r < 10)
				send_item(REQ_LOAD, rfeat(), rfeat(), rfeat(), rfeat(), 6'($urandom),
					16'($urandom));
			else if (r < 60)
				send_item(REQ_TRAIN, rfeat(), rfeat(), rfeat(), rfeat(), 6'($urandom),
					16'($urandom));
			else
				send_item(r[0] ? REQ_INFER : REQ_SPARE, rfeat(), rfeat(), rfeat(), rfeat(),
					6'($urandom), 16'($urandom));
		end
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_cycles = 600;
		@(negedge clk);
		for (int j = 0; j < 8; j++)
			send_item(REQ_TRAIN, rfeat(), rfeat(), 16'h1000, rfeat(), 6'd0, 16'd0);
	endtask

	task automatic test_rates(logic [15:0] ho, logic [15:0] ih, int n);
		wait_drain();
		write_reg(REG_RATE_HO, ho);
		write_reg(REG_RATE_IH, ih);
		test_random(n);
	endtask

	initial begin
		lr_out = 655;
		lr_hid = 6554;
		foreach (w_hid[i]) w_hid[i] = 0;
		foreach (w_out[i]) w_out[i] = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		load_random_weights();
		test_random(200);
		test_backpressure();
		test_rates(16'hffff, 16'hffff, 200);
		test_rates(16'h0000, 16'h0000, 150);
		test_rates(16'h8000, 16'h0001, 200);
		test_rates(16'd2000, 16'd20000, 200);
		wait_drain();
		quiet = 1;
		test_random(150);
		wait_drain();
		if (fail_cnt == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
